[rtl/bbpa_pkg.sv]
// Shared types, constants and mask helpers for the bitmap byte pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package bbpa_pkg;

    localparam int LEN_W  = 26;   // element_size * element_count
    localparam int WORD_W = 32;   // bytes covered by one bitmap word

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic       found;
        logic [4:0] end_bit;
    } scan_res_t;

    // ones in bits [0, n), n in 0..32
    function automatic logic [WORD_W-1:0] low_mask(input logic [5:0] n);
        logic [63:0] m;
        m = (64'd1 << n) - 64'd1;
        return m[WORD_W-1:0];
    endfunction

    // ones in bits [lo, hi)
    function automatic logic [WORD_W-1:0] range_mask(input logic [5:0] lo,
                                                     input logic [5:0] hi);
        return low_mask(hi) & ~low_mask(lo);
    endfunction

endpackage
`default_nettype wire

[rtl/bbpa_word_scan.sv]
// First-fit free run detector over one bitmap word, with the run carried in.
`timescale 1ns / 1ps
`default_nettype none
module bbpa_word_scan
    import bbpa_pkg::*;
#(
    parameter int RUN_W = 13
) (
    input  wire logic [WORD_W-1:0] used,
    input  wire logic [5:0]        nvalid,
    input  wire logic [RUN_W-1:0]  run_in,
    input  wire logic [LEN_W-1:0]  len,
    output scan_res_t              res,
    output logic      [RUN_W-1:0]  run_out
);

    localparam int XW = (LEN_W > RUN_W ? LEN_W : RUN_W) + 2;

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] tail;
    logic [63:0]       g [0:5];
    logic [63:0]       win;
    logic [6:0]        off;
    logic [WORD_W-1:0] cand;
    logic [XW-1:0]     run_x;
    logic [XW-1:0]     len_x;
    logic [XW-1:0]     b0_x;
    logic [WORD_W-1:0] long_mask;
    logic              long_ok;
    logic              short_ok;
    logic [4:0]        short_bit;
    logic [5:0]        lead;

    always_comb begin
        free_bits = ~used & low_mask(nvalid);
        run_x     = XW'(run_in);
        len_x     = XW'(len);
        if (run_x >= XW'(WORD_W)) begin
            tail = '1;
        end else begin
            tail = ~({WORD_W{1'b1}} >> run_in[4:0]);
        end

        // g[j][i]: 2**j free bytes end at position i
        g[0] = {free_bits, tail};
        for (int j = 1; j < 6; j++) begin
            g[j] = g[j-1] & (g[j-1] << (1 << (j - 1)));
        end
        win = '1;
        off = '0;
        for (int j = 0; j < 6; j++) begin
            if (len[j]) begin
                win = win & (g[j] << off);
                off = off + 7'(1 << j);
            end
        end
        cand = win[63:32];

        short_ok  = |cand;
        short_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                short_bit = 5'(i);
            end
        end

        // long runs must start at or before bit 0 of this word
        b0_x      = len_x - XW'(1) - run_x;
        long_mask = low_mask(6'(b0_x[4:0]) + 6'd1);
        long_ok   = (run_x + XW'(WORD_W) >= len_x) && (run_x < len_x)
                    && ((free_bits & long_mask) == long_mask);

        if (len_x <= XW'(WORD_W)) begin
            res.found   = short_ok;
            res.end_bit = short_bit;
        end else begin
            res.found   = long_ok;
            res.end_bit = b0_x[4:0];
        end

        lead = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!free_bits[i]) begin
                lead = 6'(WORD_W - 1 - i);
            end
        end
        if (free_bits == '1) begin
            run_out = RUN_W'(run_x + XW'(WORD_W));
        end else begin
            run_out = RUN_W'(lead);
        end
    end

endmodule
`default_nettype wire

[rtl/bitmap_byte_pool_allocator_unit.sv]
// Top level: bitmap first-fit byte pool allocator with rear pointer.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------------------
//   request  | s_valid, s_ready  | s_op, s_element_size, s_element_count,
//            |                   | s_free_offset
//   result   | m_valid, m_ready  | m_status, m_alloc_offset
//
// One request at a time; every bitmap word touched takes a memory read, then a
// test or read-modify-write, through the single bitmap port.
// Alloc: checks words in the rear range, else searches words below rear, then
// marks words. Free: clears words, then scans down for the new rear.
// After reset a clearing pass writes POOL_BYTES/32 words before s_ready rises.
// A result waits in an output register while m_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_byte_pool_allocator_unit
    import bbpa_pkg::*;
#(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [12:0] s_element_size,
    input  wire logic [12:0] s_element_count,
    input  wire logic [11:0] s_free_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [12:0]      m_alloc_offset
);

    localparam int WORDS = POOL_BYTES / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = $clog2(POOL_BYTES + 1);
    localparam int XW    = (LEN_W > OW ? LEN_W : OW) + 2;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_RCHK_RD = 4'd3;
    localparam logic [3:0] S_RCHK    = 4'd4;
    localparam logic [3:0] S_MARK_RD = 4'd5;
    localparam logic [3:0] S_MARK_WR = 4'd6;
    localparam logic [3:0] S_SRCH_RD = 4'd7;
    localparam logic [3:0] S_SRCH    = 4'd8;
    localparam logic [3:0] S_FREE_RD = 4'd9;
    localparam logic [3:0] S_FREE_WR = 4'd10;
    localparam logic [3:0] S_REAR_RD = 4'd11;
    localparam logic [3:0] S_REAR    = 4'd12;
    localparam logic [3:0] S_FIN     = 4'd13;

    logic [WORD_W-1:0] mem [0:WORDS-1];
    logic [WORD_W-1:0] rdata_reg;

    logic [3:0]       state_reg,  state_next;
    logic [WAW-1:0]   word_reg,   word_next;
    logic             op_reg;
    logic [LEN_W-1:0] len_reg;
    logic [11:0]      offs_reg;
    logic [OW-1:0]    rear_reg,   rear_next;
    logic [OW-1:0]    s_reg,      s_next;
    logic [OW-1:0]    e_reg,      e_next;
    logic [OW-1:0]    run_reg,    run_next;
    logic             rpath_reg,  rpath_next;
    logic [1:0]       st_reg,     st_next;
    logic [OW-1:0]    res_reg,    res_next;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [12:0]      m_off_reg;

    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    logic [XW-1:0]     len_x, rear_x, offs_x, s_x, e_x, base_x, pool_x, a_x;
    logic [XW-1:0]     last_x, word_x, lim_x;
    logic [5:0]        lo, hi, nvalid;
    logic [WORD_W-1:0] rmask;
    logic [WORD_W-1:0] top_used;
    logic [4:0]        top_bit;
    logic              last_word;
    scan_res_t         scan;
    logic [OW-1:0]     scan_run;
    logic [XW-1:0]     res_x;

    bbpa_word_scan #(
        .RUN_W (OW)
    ) u_scan (
        .used    (rdata_reg),
        .nvalid  (nvalid),
        .run_in  (run_reg),
        .len     (len_reg),
        .res     (scan),
        .run_out (scan_run)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[word_reg] <= mem_wdata;
        end
        rdata_reg <= mem[word_reg];
    end

    always_comb begin
        len_x  = XW'(len_reg);
        rear_x = XW'(rear_reg);
        offs_x = XW'(offs_reg);
        s_x    = XW'(s_reg);
        e_x    = XW'(e_reg);
        pool_x = XW'(POOL_BYTES);
        word_x = XW'(word_reg);
        base_x = word_x << 5;
        last_x = (e_x - XW'(1)) >> 5;
        last_word = (word_x == last_x);

        lo = (s_x > base_x) ? 6'(s_x - base_x) : 6'd0;
        hi = (e_x < base_x + XW'(WORD_W)) ? 6'(e_x - base_x) : 6'd32;
        rmask = range_mask(lo, hi);
        nvalid = hi;   // e_reg also serves as the search / rear-scan limit

        top_used = rdata_reg & low_mask(nvalid);
        top_bit  = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (top_used[i]) begin
                top_bit = 5'(i);
            end
        end
        a_x   = base_x + XW'(scan.end_bit);
        lim_x = (word_x << 5) + XW'(top_bit) + XW'(1);
    end

    always_comb begin
        state_next = state_reg;
        word_next  = word_reg;
        rear_next  = rear_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        run_next   = run_reg;
        rpath_next = rpath_reg;
        st_next    = st_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_wdata  = rdata_reg;

        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                word_next = word_reg + WAW'(1);
                if (word_x == XW'(WORDS - 1)) begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                st_next  = ST_DONE;
                res_next = '0;
                if (op_reg == OP_ALLOC) begin
                    if (len_x <= pool_x - rear_x) begin
                        if (len_x == '0) begin
                            res_next   = rear_reg;
                            state_next = S_FIN;
                        end else begin
                            s_next     = rear_reg;
                            e_next     = OW'(rear_x + len_x);
                            word_next  = WAW'(rear_x >> 5);
                            state_next = S_RCHK_RD;
                        end
                    end else if (rear_reg == '0) begin
                        st_next    = ST_NOFIT;
                        state_next = S_FIN;
                    end else begin
                        e_next     = rear_reg;
                        s_next     = '0;
                        run_next   = '0;
                        word_next  = '0;
                        state_next = S_SRCH_RD;
                    end
                end else begin
                    if (offs_x > pool_x || len_x > pool_x - offs_x) begin
                        st_next    = ST_RANGE;
                        state_next = S_FIN;
                    end else if (len_x == '0) begin
                        if (rear_reg == '0) begin
                            state_next = S_FIN;
                        end else begin
                            s_next     = '0;
                            e_next     = rear_reg;
                            word_next  = WAW'((rear_x - XW'(1)) >> 5);
                            state_next = S_REAR_RD;
                        end
                    end else begin
                        s_next     = OW'(offs_x);
                        e_next     = OW'(offs_x + len_x);
                        word_next  = WAW'(offs_x >> 5);
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_RCHK_RD: state_next = S_RCHK;
            S_RCHK: begin
                if ((rdata_reg & rmask) != '0) begin
                    // rear range busy: fall back to first fit below rear
                    if (rear_reg == '0) begin
                        st_next    = ST_NOFIT;
                        state_next = S_FIN;
                    end else begin
                        s_next     = '0;
                        e_next     = rear_reg;
                        run_next   = '0;
                        word_next  = '0;
                        state_next = S_SRCH_RD;
                    end
                end else if (last_word) begin
                    rpath_next = 1'b1;
                    res_next   = s_reg;
                    word_next  = WAW'(s_x >> 5);
                    state_next = S_MARK_RD;
                end else begin
                    word_next  = word_reg + WAW'(1);
                    state_next = S_RCHK_RD;
                end
            end
            S_MARK_RD: state_next = S_MARK_WR;
            S_MARK_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg | rmask;
                if (last_word) begin
                    if (rpath_reg) begin
                        rear_next = OW'(rear_x + len_x);
                    end
                    state_next = S_FIN;
                end else begin
                    word_next  = word_reg + WAW'(1);
                    state_next = S_MARK_RD;
                end
            end
            S_SRCH_RD: state_next = S_SRCH;
            S_SRCH: begin
                if (scan.found) begin
                    rpath_next = 1'b0;
                    s_next     = OW'(a_x + XW'(1) - len_x);
                    e_next     = OW'(a_x + XW'(1));
                    res_next   = OW'(a_x + XW'(1) - len_x);
                    word_next  = WAW'((a_x + XW'(1) - len_x) >> 5);
                    state_next = S_MARK_RD;
                end else if (last_word) begin
                    st_next    = ST_NOFIT;
                    state_next = S_FIN;
                end else begin
                    run_next   = scan_run;
                    word_next  = word_reg + WAW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_FREE_RD: state_next = S_FREE_WR;
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg & ~rmask;
                if (!last_word) begin
                    word_next  = word_reg + WAW'(1);
                    state_next = S_FREE_RD;
                end else if (rear_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    s_next     = '0;
                    e_next     = rear_reg;
                    word_next  = WAW'((rear_x - XW'(1)) >> 5);
                    state_next = S_REAR_RD;
                end
            end
            S_REAR_RD: state_next = S_REAR;
            S_REAR: begin
                if (top_used != '0) begin
                    rear_next  = OW'(lim_x);
                    state_next = S_FIN;
                end else if (word_reg == '0) begin
                    rear_next  = '0;
                    state_next = S_FIN;
                end else begin
                    word_next  = word_reg - WAW'(1);
                    state_next = S_REAR_RD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            word_reg    <= '0;
            rear_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            word_reg  <= word_next;
            rear_reg  <= rear_next;
            if (state_reg == S_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign res_x = XW'(res_reg);

    always_ff @(posedge aclk) begin
        s_reg     <= s_next;
        e_reg     <= e_next;
        run_reg   <= run_next;
        rpath_reg <= rpath_next;
        st_reg    <= st_next;
        res_reg   <= res_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg   <= s_op;
            len_reg  <= LEN_W'(s_element_size) * LEN_W'(s_element_count);
            offs_reg <= s_free_offset;
        end
        if (state_reg == S_FIN && (!m_valid_reg || m_ready)) begin
            m_status_reg <= st_reg;
            m_off_reg    <= res_x[12:0];
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_offset = m_off_reg;

`ifndef ASSERT_OFF
    a_rear_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        rear_reg <= OW'(POOL_BYTES))
        else $error("rear pointer beyond pool");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready while a request is in progress");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE || m_status == ST_NOFIT ||
                     m_status == ST_RANGE))
        else $error("undefined status code");

    a_fail_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_alloc_offset == '0))
        else $error("offset reported on failure");
`endif

endmodule
`default_nettype wire
